@@ rtl/mse_pkg.sv @@
`timescale 1ns / 1ps

package mse_pkg;

    // Default size of the instruction store, in words.
    localparam int IMEM_DEPTH_DEF = 1024;

    // Item commands on the input channel.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    // Primary opcodes of the supported instructions.
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_ADDI    = 6'd8;

    // Function codes under the SPECIAL opcode.
    localparam logic [5:0] FN_SLL = 6'd0;
    localparam logic [5:0] FN_SRL = 6'd2;
    localparam logic [5:0] FN_SRA = 6'd3;
    localparam logic [5:0] FN_ADD = 6'd32;
    localparam logic [5:0] FN_AND = 6'd36;
    localparam logic [5:0] FN_OR  = 6'd37;
    localparam logic [5:0] FN_SLT = 6'd42;

    // Outcome of executing one instruction.
    typedef struct packed {
        logic [1:0]  status;
        logic        we;
        logic [4:0]  waddr;
        logic [31:0] wdata;
        logic [31:0] pc_next;
    } t_exec_res;

endpackage

@@ rtl/mse_ifs.sv @@
`timescale 1ns / 1ps

interface mse_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [9:0]  load_index;
    logic [31:0] load_word;
    logic [4:0]  reg_index;

    modport source (output valid, output opcode, output load_index, output load_word,
                    output reg_index, input ready);
    modport sink   (input valid, input opcode, input load_index, input load_word,
                    input reg_index, output ready);
endinterface

interface mse_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] read_value;
    logic [31:0] pc_now;

    modport source (output valid, output status, output read_value, output pc_now,
                    input ready);
    modport sink   (input valid, input status, input read_value, input pc_now,
                    output ready);
endinterface

interface mse_cfg_if;
    logic        valid;
    logic        ready;
    logic [10:0] program_length;

    modport source (output valid, output program_length, input ready);
    modport sink   (input valid, input program_length, output ready);
endinterface

@@ rtl/mse_imem.sv @@
`timescale 1ns / 1ps

module mse_imem #(
    parameter int DEPTH = mse_pkg::IMEM_DEPTH_DEF,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [31:0]   o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // The read data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/mse_rf.sv @@
`timescale 1ns / 1ps

module mse_rf (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_we,
    input  logic [4:0]  i_waddr,
    input  logic [31:0] i_wdata,
    input  logic        i_re,
    input  logic [4:0]  i_raddr_a,
    input  logic [4:0]  i_raddr_b,
    output logic [31:0] o_rdata_a,
    output logic [31:0] o_rdata_b
);

    logic [31:0] r_mem [32];
    logic [31:0] r_vld;
    logic [31:0] r_rdata_a;
    logic [31:0] r_rdata_b;
    logic        wr;

    // Register zero is never written, so it never becomes valid and reads zero.
    assign wr = i_we && (i_waddr != 5'd0);

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    // A write in the same cycle as a read of the same entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            if (wr && (i_waddr == i_raddr_a)) begin
                r_rdata_a <= i_wdata;
            end else begin
                r_rdata_a <= r_vld[i_raddr_a] ? r_mem[i_raddr_a] : 32'd0;
            end
            if (wr && (i_waddr == i_raddr_b)) begin
                r_rdata_b <= i_wdata;
            end else begin
                r_rdata_b <= r_vld[i_raddr_b] ? r_mem[i_raddr_b] : 32'd0;
            end
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/mse_alu.sv @@
`timescale 1ns / 1ps

module mse_alu (
    input  logic [31:0]         i_ins,
    input  logic [31:0]         i_a,
    input  logic [31:0]         i_b,
    input  logic [31:0]         i_pc,
    input  logic [31:0]         i_pc4,
    input  logic                i_end,
    output mse_pkg::t_exec_res  o_res
);
    import mse_pkg::*;

    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [31:0] imm;
    logic [31:0] br_tgt;
    t_exec_res   res;

    assign op     = i_ins[31:26];
    assign rt     = i_ins[20:16];
    assign rd     = i_ins[15:11];
    assign sa     = i_ins[10:6];
    assign fn     = i_ins[5:0];
    assign imm    = {{16{i_ins[15]}}, i_ins[15:0]};
    assign br_tgt = i_pc4 + {imm[29:0], 2'b00};

    always_comb begin
        res.status  = ST_OK;
        res.we      = 1'b0;
        res.waddr   = rd;
        res.wdata   = 32'd0;
        res.pc_next = i_pc4;
        if (i_end) begin
            res.status  = ST_END;
            res.pc_next = i_pc;
        end else begin
            unique case (op)
                OP_ADDI: begin
                    res.we    = 1'b1;
                    res.waddr = rt;
                    res.wdata = i_a + imm;
                end
                OP_BEQ: begin
                    if (i_a == i_b) begin
                        res.pc_next = br_tgt;
                    end
                end
                OP_BNE: begin
                    if (i_a != i_b) begin
                        res.pc_next = br_tgt;
                    end
                end
                OP_SPECIAL: begin
                    res.we = 1'b1;
                    unique case (fn)
                        FN_ADD:  res.wdata = i_a + i_b;
                        FN_AND:  res.wdata = i_a & i_b;
                        FN_OR:   res.wdata = i_a | i_b;
                        FN_SLL:  res.wdata = i_b << sa;
                        FN_SRL:  res.wdata = i_b >> sa;
                        FN_SRA:  res.wdata = $unsigned($signed(i_b) >>> sa);
                        FN_SLT:  res.wdata = {31'd0, $signed(i_a) < $signed(i_b)};
                        default: begin
                            res.we     = 1'b0;
                            res.status = ST_UNKNOWN;
                        end
                    endcase
                end
                default: begin
                    res.status = ST_UNKNOWN;
                end
            endcase
        end
    end

    assign o_res = res;

endmodule

@@ rtl/mips_subset_instruction_executor.sv @@
`timescale 1ns / 1ps

// Channel  | Direction | Transfer when           | Payload
// ---------+-----------+-------------------------+-------------------------------------
// i_in     | sink      | i_in.valid & ready      | opcode, load_index, load_word, reg_index
// o_out    | source    | o_out.valid & ready     | status, read_value, pc_now
// i_cfg    | sink      | i_cfg.valid & ready     | program_length (ready is always high)
//
// The instruction store is read in the cycle of the transfer, the register file as the item
// leaves decode; input ready stays low until then. A result passes through the decode and
// execute registers into the output register. Reset (i_rst_n low at a clock edge) empties
// the pipeline, zeroes the program counter and program_length and marks every register as
// zero; the instruction store is not cleared. A stalled output register holds the execute
// stage, which in turn holds the decode stage and input ready.

module mips_subset_instruction_executor #(
    parameter int IMEM_DEPTH = mse_pkg::IMEM_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mse_in_if.sink    i_in,
    mse_out_if.source o_out,
    mse_cfg_if.sink   i_cfg
);
    import mse_pkg::*;

    localparam int AW = $clog2(IMEM_DEPTH);

    // Configuration.
    logic [10:0] r_plen;

    // Architectural program counter, updated when an item leaves execute.
    logic [31:0] r_pc;
    logic [31:0] n_pc;
    logic [31:0] pc_cur;

    // Decode stage: the instruction word arrives from the store here.
    logic        r_s1_vld;
    logic [1:0]  r_s1_cmd;
    logic [31:0] r_s1_pc;
    logic        r_s1_oob;
    logic [4:0]  r_s1_ridx;
    logic [31:0] s1_ins;
    logic        s1_end;

    // Execute stage: register operands arrive from the register file here.
    logic        r_s2_vld;
    logic [1:0]  r_s2_cmd;
    logic [31:0] r_s2_pc;
    logic [31:0] r_s2_pc4;
    logic        r_s2_end;
    logic [31:0] r_s2_ins;

    // Output register.
    logic        r_o_vld;
    logic [1:0]  r_o_status;
    logic [31:0] r_o_value;
    logic [31:0] r_o_pc;

    logic        in_xfer;
    logic        out_free;
    logic        s2_adv;
    logic        s2_free;
    logic        s1_adv;

    logic          imem_we;
    logic [AW-1:0] imem_waddr;
    logic [AW-1:0] imem_raddr;
    logic [31:0]   imem_rdata;
    logic [31:0]   lidx_ext;

    logic [31:0] rf_a;
    logic [31:0] rf_b;
    logic [4:0]  rf_raddr_a;
    logic        rf_we;

    t_exec_res   exec;
    logic [1:0]  res_status;
    logic [31:0] res_value;

    // Flow control. Only one item sits in decode at a time, because the next
    // step needs the program counter this one leaves behind.
    assign out_free = !r_o_vld || o_out.ready;
    assign s2_adv   = r_s2_vld && out_free;
    assign s2_free  = !r_s2_vld || s2_adv;
    assign s1_adv   = r_s1_vld && s2_free;

    assign i_in.ready  = !r_s1_vld;
    assign in_xfer     = i_in.valid && !r_s1_vld;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen <= 11'd0;
        end else if (i_cfg.valid) begin
            r_plen <= i_cfg.program_length;
        end
    end

    // Program counter after the item in execute: a load rewinds it, a step
    // takes the executed outcome, anything else leaves it alone.
    always_comb begin
        unique case (r_s2_cmd)
            CMD_LOAD: n_pc = 32'd0;
            CMD_STEP: n_pc = exec.pc_next;
            default:  n_pc = r_s2_pc;
        endcase
    end

    // The item in execute (if any) is older than a new input item, so its
    // counter is forwarded to the fetch address.
    assign pc_cur = r_s2_vld ? n_pc : r_pc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= 32'd0;
        end else if (s2_adv) begin
            r_pc <= n_pc;
        end
    end

    // Instruction store. Loads write at the transfer; steps fetch at the
    // transfer. Words beyond the store read as zero.
    assign lidx_ext   = 32'(i_in.load_index);
    assign imem_waddr = lidx_ext[AW-1:0];
    assign imem_we    = in_xfer && (i_in.opcode == CMD_LOAD)
                        && (lidx_ext < 32'(IMEM_DEPTH));
    assign imem_raddr = pc_cur[AW+1:2];

    mse_imem #(
        .DEPTH (IMEM_DEPTH)
    ) u_imem (
        .i_clk   (i_clk),
        .i_we    (imem_we),
        .i_waddr (imem_waddr),
        .i_wdata (i_in.load_word),
        .i_re    (in_xfer && (i_in.opcode == CMD_STEP)),
        .i_raddr (imem_raddr),
        .o_rdata (imem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (in_xfer) begin
            r_s1_vld <= 1'b1;
        end else if (s1_adv) begin
            r_s1_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_cmd  <= i_in.opcode;
            r_s1_pc   <= pc_cur;
            r_s1_oob  <= {2'b00, pc_cur[31:2]} >= 32'(IMEM_DEPTH);
            r_s1_ridx <= i_in.reg_index;
        end
    end

    // Decode: the program may run only while pc < 4 * program_length.
    assign s1_ins     = r_s1_oob ? 32'd0 : imem_rdata;
    assign s1_end     = r_s1_pc >= {19'd0, r_plen, 2'b00};
    assign rf_raddr_a = (r_s1_cmd == CMD_READ) ? r_s1_ridx : s1_ins[25:21];

    // The register file is read as the item moves into execute; a write-back
    // from execute at the same edge is forwarded inside the register file.
    mse_rf u_rf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (rf_we),
        .i_waddr   (exec.waddr),
        .i_wdata   (exec.wdata),
        .i_re      (s1_adv),
        .i_raddr_a (rf_raddr_a),
        .i_raddr_b (s1_ins[20:16]),
        .o_rdata_a (rf_a),
        .o_rdata_b (rf_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s1_adv) begin
            r_s2_vld <= 1'b1;
        end else if (s2_adv) begin
            r_s2_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_cmd <= r_s1_cmd;
            r_s2_pc  <= r_s1_pc;
            r_s2_pc4 <= r_s1_pc + 32'd4;
            r_s2_end <= s1_end;
            r_s2_ins <= s1_ins;
        end
    end

    // Execute.
    mse_alu u_alu (
        .i_ins (r_s2_ins),
        .i_a   (rf_a),
        .i_b   (rf_b),
        .i_pc  (r_s2_pc),
        .i_pc4 (r_s2_pc4),
        .i_end (r_s2_end),
        .o_res (exec)
    );

    assign rf_we      = s2_adv && (r_s2_cmd == CMD_STEP) && exec.we;
    assign res_status = (r_s2_cmd == CMD_STEP) ? exec.status : ST_OK;
    assign res_value  = (r_s2_cmd == CMD_READ) ? rf_a : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (s2_adv) begin
            r_o_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_o_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_o_status <= res_status;
            r_o_value  <= res_value;
            r_o_pc     <= n_pc;
        end
    end

    assign o_out.valid      = r_o_vld;
    assign o_out.status     = r_o_status;
    assign o_out.read_value = r_o_value;
    assign o_out.pc_now     = r_o_pc;

endmodule

@@ rtl/mse_chk.sv @@
`timescale 1ns / 1ps

module mse_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  i_out_status,
    input logic [31:0] i_out_read_value,
    input logic [31:0] i_out_pc_now
);
    import mse_pkg::*;

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result withdrawn before its transfer");

    // An input transfer fills the decode stage, which holds input ready low until it drains.
    a_issue_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken in two consecutive cycles");

    // Only read items carry register data, and they always report ok.
    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_status != ST_OK) |-> i_out_read_value == 32'd0)
        else $error("nonzero read value on a step result");

    // Branch targets and increments keep the counter word aligned.
    a_pc_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_pc_now[1:0] == 2'b00)
        else $error("program counter not word aligned");

endmodule

bind mips_subset_instruction_executor mse_chk u_mse_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_out_status     (o_out.status),
    .i_out_read_value (o_out.read_value),
    .i_out_pc_now     (o_out.pc_now)
);
